### design/snor_pkg.sv
// Shared types, codes and byte constants for the SPI NOR command sequencer.
// Holds the step decoder used by the back end. No dependencies.
`default_nettype none
package snor_pkg;

    localparam int ADDR_W      = 24;
    localparam int LEN_W       = 25;
    localparam int BYTE_W      = 8;
    localparam int STEP_W      = 4;
    localparam int PAGE_BYTES  = 256;   // power of two
    localparam int QUEUE_DEPTH = 4;

    localparam logic [BYTE_W-1:0] OPC_WREN  = 8'h06;
    localparam logic [BYTE_W-1:0] OPC_PROG  = 8'h02;
    localparam logic [BYTE_W-1:0] OPC_READ  = 8'h03;
    localparam logic [BYTE_W-1:0] OPC_ERASE = 8'h20;
    localparam logic [BYTE_W-1:0] OPC_JEDEC = 8'h9F;
    localparam logic [BYTE_W-1:0] OPC_MFR   = 8'hAB;
    localparam logic [BYTE_W-1:0] DUMMY     = 8'hFF;

    typedef enum logic [2:0] {
        OP_WRITE_REQ = 3'd0,
        OP_DATA      = 3'd1,
        OP_READ_REQ  = 3'd2,
        OP_SLOT      = 3'd3,
        OP_ERASE     = 3'd4,
        OP_JEDEC     = 3'd5,
        OP_MFR       = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        K_SEND    = 2'd0,
        K_RELEASE = 2'd1,
        K_POLL    = 2'd2,
        K_REFUSED = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_WRITE = 3'b010,
        MODE_READ  = 3'b100
    } t_mode;

    typedef enum logic [2:0] {
        FR_REFUSED = 3'd0,
        FR_PROG    = 3'd1,
        FR_READ    = 3'd2,
        FR_SLOT    = 3'd3,
        FR_ERASE   = 3'd4,
        FR_JEDEC   = 3'd5,
        FR_MFR     = 3'd6
    } t_frame;

    typedef struct packed {
        t_frame              frame;
        logic                hdr;     // program frame opens here
        logic                close;   // frame ends after this item
        logic [ADDR_W-1:0]   addr;
        logic [BYTE_W-1:0]   data;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_cmd_push;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] value;
        logic              last;
    } t_result;

    function automatic logic [STEP_W-1:0] first_step(t_cmd c);
        logic [STEP_W-1:0] s;
        s = '0;
        if (c.frame == FR_PROG && !c.hdr) begin
            s = 4'd6;
        end
        return s;
    endfunction

    function automatic t_result cmd_step(t_cmd c, logic [STEP_W-1:0] s);
        t_result r;
        r.kind  = K_SEND;
        r.value = '0;
        r.last  = 1'b0;
        case (c.frame)
            FR_REFUSED: begin
                r.kind = K_REFUSED;
                r.last = 1'b1;
            end
            FR_PROG: begin
                case (s)
                    4'd0: r.value = OPC_WREN;
                    4'd1: r.kind  = K_RELEASE;
                    4'd2: r.value = OPC_PROG;
                    4'd3: r.value = c.addr[23:16];
                    4'd4: r.value = c.addr[15:8];
                    4'd5: r.value = c.addr[7:0];
                    4'd6: begin
                        r.value = c.data;
                        r.last  = !c.close;
                    end
                    4'd7: r.kind = K_RELEASE;
                    default: begin
                        r.kind = K_POLL;
                        r.last = 1'b1;
                    end
                endcase
            end
            FR_READ: begin
                case (s)
                    4'd0: r.value = OPC_READ;
                    4'd1: r.value = c.addr[23:16];
                    4'd2: r.value = c.addr[15:8];
                    default: begin
                        r.value = c.addr[7:0];
                        r.last  = 1'b1;
                    end
                endcase
            end
            FR_SLOT: begin
                case (s)
                    4'd0: begin
                        r.value = DUMMY;
                        r.last  = !c.close;
                    end
                    default: begin
                        r.kind = K_RELEASE;
                        r.last = 1'b1;
                    end
                endcase
            end
            FR_ERASE: begin
                case (s)
                    4'd0: r.value = OPC_WREN;
                    4'd1: r.kind  = K_RELEASE;
                    4'd2: r.value = OPC_ERASE;
                    4'd3: r.value = c.addr[23:16];
                    4'd4: r.value = c.addr[15:8];
                    4'd5: r.value = c.addr[7:0];
                    4'd6: r.kind  = K_RELEASE;
                    default: begin
                        r.kind = K_POLL;
                        r.last = 1'b1;
                    end
                endcase
            end
            FR_JEDEC: begin
                case (s)
                    4'd0: r.value = OPC_JEDEC;
                    4'd1, 4'd2, 4'd3: r.value = DUMMY;
                    default: begin
                        r.kind = K_RELEASE;
                        r.last = 1'b1;
                    end
                endcase
            end
            default: begin
                case (s)
                    4'd0: r.value = OPC_MFR;
                    4'd1, 4'd2, 4'd3, 4'd4: r.value = DUMMY;
                    default: begin
                        r.kind = K_RELEASE;
                        r.last = 1'b1;
                    end
                endcase
            end
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

### design/spi_nor_command_sequencer_unit.sv
// SPI NOR command sequencer, top level.
// Requests enter a queue-style port: a transfer happens when push is high and
// full is low. Link actions leave a queue-style port: the oldest action is on
// o_kind/o_value/o_last while empty is low and is taken when pop is high.
// The front end handles one request per cycle while full is low and writes a
// frame command into a short queue; write requests and zero-length read
// requests taken while idle produce no command. The back end expands each
// command into 1 to 9 actions, one per cycle while the receiver keeps up,
// through a single result register, so a request occupies the back end until
// all its actions are out (9 for a data byte that both opens and closes a
// program frame, 7 for one that only opens it, 8 for an erase, 1 for a plain
// data byte or refusal). A request's first action is written into the queue,
// then the back end's current command register, then the result register.
// When the receiver stalls, the result register holds, the back end waits,
// and the queue fills; full rises once the queue is full.
// A synchronous reset returns the transfer state to idle and empties the
// queue and result register; no action is pending after reset.
// Depends on snor_pkg, snor_front, snor_queue and snor_back.
`default_nettype none
module spi_nor_command_sequencer_unit #(
    parameter int PAGE_BYTES  = snor_pkg::PAGE_BYTES,
    parameter int QUEUE_DEPTH = snor_pkg::QUEUE_DEPTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [2:0]                  i_op,
    input  wire logic [snor_pkg::ADDR_W-1:0] i_address,
    input  wire logic [snor_pkg::LEN_W-1:0]  i_length,
    input  wire logic [snor_pkg::BYTE_W-1:0] i_data_byte,
    output logic                             empty,
    input  wire logic                        pop,
    output logic [1:0]                       o_kind,
    output logic [snor_pkg::BYTE_W-1:0]      o_value,
    output logic                             o_last
);

    snor_pkg::t_cmd_push  fq_wr;
    snor_pkg::t_cmd       q_cmd;
    snor_pkg::t_result    res;
    logic                 q_empty, q_pop;

    snor_front #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (push && !full),
        .i_op        (i_op),
        .i_address   (i_address),
        .i_length    (i_length),
        .i_data_byte (i_data_byte),
        .o_cmd       (fq_wr)
    );

    snor_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fq_wr),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_full  (full),
        .o_empty (q_empty)
    );

    snor_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_empty (q_empty),
        .o_cmd_pop   (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (res)
    );

    assign o_kind  = res.kind;
    assign o_value = res.value;
    assign o_last  = res.last;

endmodule
`default_nettype wire

### design/snor_front.sv
// Front end: accepts host requests, tracks transfer state, classifies each
// item into a frame command. Depends on snor_pkg.
`default_nettype none
module snor_front #(
    parameter int PAGE_BYTES = snor_pkg::PAGE_BYTES
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire logic [2:0]                  i_op,
    input  wire logic [snor_pkg::ADDR_W-1:0] i_address,
    input  wire logic [snor_pkg::LEN_W-1:0]  i_length,
    input  wire logic [snor_pkg::BYTE_W-1:0] i_data_byte,
    output snor_pkg::t_cmd_push              o_cmd
);

    localparam int PAGE_W = $clog2(PAGE_BYTES);

    snor_pkg::t_mode               r_mode, n_mode;
    logic [snor_pkg::ADDR_W-1:0]   r_next_addr, n_next_addr;
    logic [snor_pkg::LEN_W-1:0]    r_remaining, n_remaining;
    logic                          r_frame_open, n_frame_open;

    logic [snor_pkg::ADDR_W-1:0]   addr_inc;
    logic [snor_pkg::LEN_W-1:0]    rem_dec;
    logic                          busy;
    logic                          page_end;

    assign addr_inc = r_next_addr + 1'b1;
    assign rem_dec  = r_remaining - 1'b1;
    assign busy     = (r_mode != snor_pkg::MODE_IDLE);
    assign page_end = (addr_inc[PAGE_W-1:0] == '0);

    always_comb begin
        n_mode         = r_mode;
        n_next_addr    = r_next_addr;
        n_remaining    = r_remaining;
        n_frame_open   = r_frame_open;
        o_cmd.push       = 1'b0;
        o_cmd.cmd.frame  = snor_pkg::FR_REFUSED;
        o_cmd.cmd.hdr    = 1'b0;
        o_cmd.cmd.close  = 1'b0;
        o_cmd.cmd.addr   = i_address;
        o_cmd.cmd.data   = i_data_byte;
        if (i_accept) begin
            o_cmd.push = 1'b1;
            case (snor_pkg::t_op'(i_op))
                snor_pkg::OP_WRITE_REQ: begin
                    if (!busy) begin
                        o_cmd.push = 1'b0;
                        if (i_length != '0) begin
                            n_mode       = snor_pkg::MODE_WRITE;
                            n_next_addr  = i_address;
                            n_remaining  = i_length;
                            n_frame_open = 1'b0;
                        end
                    end
                end
                snor_pkg::OP_DATA: begin
                    if (r_mode == snor_pkg::MODE_WRITE && r_remaining != '0) begin
                        o_cmd.cmd.frame = snor_pkg::FR_PROG;
                        o_cmd.cmd.hdr   = !r_frame_open;
                        o_cmd.cmd.addr  = r_next_addr;
                        o_cmd.cmd.close = (rem_dec == '0) || page_end;
                        n_next_addr     = addr_inc;
                        n_remaining     = rem_dec;
                        n_frame_open    = !((rem_dec == '0) || page_end);
                        if (rem_dec == '0) begin
                            n_mode = snor_pkg::MODE_IDLE;
                        end
                    end
                end
                snor_pkg::OP_READ_REQ: begin
                    if (!busy) begin
                        o_cmd.cmd.frame = snor_pkg::FR_READ;
                        o_cmd.push      = (i_length != '0);
                        if (i_length != '0) begin
                            n_mode       = snor_pkg::MODE_READ;
                            n_next_addr  = i_address;
                            n_remaining  = i_length;
                            n_frame_open = 1'b0;
                        end
                    end
                end
                snor_pkg::OP_SLOT: begin
                    if (r_mode == snor_pkg::MODE_READ && r_remaining != '0) begin
                        o_cmd.cmd.frame = snor_pkg::FR_SLOT;
                        o_cmd.cmd.close = (rem_dec == '0);
                        n_next_addr     = addr_inc;
                        n_remaining     = rem_dec;
                        if (rem_dec == '0) begin
                            n_mode = snor_pkg::MODE_IDLE;
                        end
                    end
                end
                snor_pkg::OP_ERASE: begin
                    if (!busy) o_cmd.cmd.frame = snor_pkg::FR_ERASE;
                end
                snor_pkg::OP_JEDEC: begin
                    if (!busy) o_cmd.cmd.frame = snor_pkg::FR_JEDEC;
                end
                snor_pkg::OP_MFR: begin
                    if (!busy) o_cmd.cmd.frame = snor_pkg::FR_MFR;
                end
                default: begin
                    o_cmd.cmd.frame = snor_pkg::FR_REFUSED;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= snor_pkg::MODE_IDLE;
            r_next_addr  <= '0;
            r_remaining  <= '0;
            r_frame_open <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_next_addr  <= n_next_addr;
            r_remaining  <= n_remaining;
            r_frame_open <= n_frame_open;
        end
    end

endmodule
`default_nettype wire

### design/snor_queue.sv
// Short command queue between front and back end.
// Register-based FIFO of t_cmd entries. Depends on snor_pkg.
`default_nettype none
module snor_queue #(
    parameter int DEPTH = snor_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  snor_pkg::t_cmd_push i_wr,
    input  wire logic           i_pop,
    output snor_pkg::t_cmd      o_cmd,
    output logic                o_full,
    output logic                o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

    snor_pkg::t_cmd     r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_wr, do_rd;

    assign o_full  = (r_count == CNT_MAX);
    assign o_empty = (r_count == '0);
    assign do_wr   = i_wr.push && !o_full;
    assign do_rd   = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_MAX) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_MAX) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

### design/snor_back.sv
// Back end: expands one frame command into link actions, one per cycle unless
// the receiver stalls, into the result register. Depends on snor_pkg.
`default_nettype none
module snor_back (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  snor_pkg::t_cmd  i_cmd,
    input  wire logic       i_cmd_empty,
    output logic            o_cmd_pop,
    input  wire logic       i_pop,
    output logic            o_empty,
    output snor_pkg::t_result o_res
);

    logic                          r_cur_valid;
    snor_pkg::t_cmd                r_cur;
    logic [snor_pkg::STEP_W-1:0]   r_step;
    logic                          r_out_valid;
    snor_pkg::t_result             r_out;

    snor_pkg::t_result             res;
    logic                          out_free, adv, done, take;

    assign res       = snor_pkg::cmd_step(r_cur, r_step);
    assign out_free  = !r_out_valid || i_pop;
    assign adv       = r_cur_valid && out_free;
    assign done      = adv && res.last;
    assign take      = !i_cmd_empty && (!r_cur_valid || done);
    assign o_cmd_pop = take;
    assign o_empty   = !r_out_valid;
    assign o_res     = r_out;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cur  <= i_cmd;
            r_step <= snor_pkg::first_step(i_cmd);
        end else if (adv) begin
            r_step <= r_step + 1'b1;
        end
        if (adv) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_cur_valid <= 1'b1;
            end else if (done) begin
                r_cur_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

### test/tb_spi_nor_command_sequencer_unit.sv
// Testbench for spi_nor_command_sequencer_unit: directed and random request streams,
// checked action by action against a behavioral predictor of the SPI NOR link sequence.
// Depends on snor_pkg and the design top level.
module tb_spi_nor_command_sequencer_unit;
    import snor_pkg::*;

    localparam logic [2:0] OP_UNKNOWN = 3'd7;
    localparam int IDLE_PCT     = 34;
    localparam int CALM_FROM    = 1200;
    localparam int CALM_TO      = 2000;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 350;
    localparam int PRINT_CAP    = 50;

    typedef struct packed {
        logic [2:0]        op;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] data;
    } t_request;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              push        = 1'b0;
    logic              full;
    logic [2:0]        i_op        = '0;
    logic [ADDR_W-1:0] i_address   = '0;
    logic [LEN_W-1:0]  i_length    = '0;
    logic [BYTE_W-1:0] i_data_byte = '0;
    logic              empty;
    logic              pop         = 1'b0;
    logic [1:0]        o_kind;
    logic [BYTE_W-1:0] o_value;
    logic              o_last;

    spi_nor_command_sequencer_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_op        (i_op),
        .i_address   (i_address),
        .i_length    (i_length),
        .i_data_byte (i_data_byte),
        .empty       (empty),
        .pop         (pop),
        .o_kind      (o_kind),
        .o_value     (o_value),
        .o_last      (o_last)
    );

    always #5 i_clk = ~i_clk;

    // predicted transfer state
    t_mode             xfer_mode = MODE_IDLE;
    logic [ADDR_W-1:0] xfer_addr = '0;
    logic [LEN_W-1:0]  xfer_left = '0;
    logic              prog_open = 1'b0;

    t_request pending_requests[$];
    t_request sent_request;
    t_result  step_actions[$];
    t_result  actions_due[$];
    t_result  due_action;

    int mismatch_count = 0;
    int action_count   = 0;
    int cycle_count    = 0;
    int quiet_cycles   = 0;

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [31:0] w;
        w = $urandom();
        return w[ADDR_W-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] rand_len();
        logic [31:0] w;
        w = $urandom();
        return w[LEN_W-1:0];
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        logic [31:0] w;
        w = $urandom();
        return w[BYTE_W-1:0];
    endfunction

    function automatic logic take_gap();
        logic calm;
        calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);
        return ($urandom_range(0, 99) < IDLE_PCT) && !calm;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_CAP) begin
            $display("mismatch at action %0d: %s", action_count, what);
        end
        mismatch_count++;
    endtask

    task automatic emit_action(input t_kind k, input logic [BYTE_W-1:0] v);
        t_result r;
        r.kind  = k;
        r.value = (k == K_SEND) ? v : '0;
        r.last  = 1'b0;
        step_actions.push_back(r);
    endtask

    task automatic emit_address(input logic [ADDR_W-1:0] a);
        emit_action(K_SEND, a[23:16]);
        emit_action(K_SEND, a[15:8]);
        emit_action(K_SEND, a[7:0]);
    endtask

    task automatic predict_link_actions(input t_request rq);
        logic    busy;
        t_result r;
        busy = (xfer_mode != MODE_IDLE);
        step_actions.delete();
        case (rq.op)
            OP_WRITE_REQ: begin
                if (busy) begin
                    emit_action(K_REFUSED, '0);
                end else if (rq.len != '0) begin
                    xfer_mode = MODE_WRITE;
                    xfer_addr = rq.addr;
                    xfer_left = rq.len;
                    prog_open = 1'b0;
                end
            end
            OP_DATA: begin
                if (xfer_mode != MODE_WRITE || xfer_left == '0) begin
                    emit_action(K_REFUSED, '0);
                end else begin
                    if (!prog_open) begin
                        emit_action(K_SEND, OPC_WREN);
                        emit_action(K_RELEASE, '0);
                        emit_action(K_SEND, OPC_PROG);
                        emit_address(xfer_addr);
                        prog_open = 1'b1;
                    end
                    emit_action(K_SEND, rq.data);
                    xfer_addr = xfer_addr + 1'b1;
                    xfer_left = xfer_left - 1'b1;
                    if (xfer_left == '0 || (xfer_addr & ADDR_W'(PAGE_BYTES - 1)) == '0) begin
                        emit_action(K_RELEASE, '0);
                        emit_action(K_POLL, '0);
                        prog_open = 1'b0;
                        if (xfer_left == '0) begin
                            xfer_mode = MODE_IDLE;
                        end
                    end
                end
            end
            OP_READ_REQ: begin
                if (busy) begin
                    emit_action(K_REFUSED, '0);
                end else if (rq.len != '0) begin
                    xfer_mode = MODE_READ;
                    xfer_addr = rq.addr;
                    xfer_left = rq.len;
                    prog_open = 1'b0;
                    emit_action(K_SEND, OPC_READ);
                    emit_address(rq.addr);
                end
            end
            OP_SLOT: begin
                if (xfer_mode != MODE_READ || xfer_left == '0) begin
                    emit_action(K_REFUSED, '0);
                end else begin
                    emit_action(K_SEND, DUMMY);
                    xfer_addr = xfer_addr + 1'b1;
                    xfer_left = xfer_left - 1'b1;
                    if (xfer_left == '0) begin
                        emit_action(K_RELEASE, '0);
                        xfer_mode = MODE_IDLE;
                    end
                end
            end
            OP_ERASE: begin
                if (busy) begin
                    emit_action(K_REFUSED, '0);
                end else begin
                    emit_action(K_SEND, OPC_WREN);
                    emit_action(K_RELEASE, '0);
                    emit_action(K_SEND, OPC_ERASE);
                    emit_address(rq.addr);
                    emit_action(K_RELEASE, '0);
                    emit_action(K_POLL, '0);
                end
            end
            OP_JEDEC: begin
                if (busy) begin
                    emit_action(K_REFUSED, '0);
                end else begin
                    emit_action(K_SEND, OPC_JEDEC);
                    for (int i = 0; i < 3; i++) begin
                        emit_action(K_SEND, DUMMY);
                    end
                    emit_action(K_RELEASE, '0);
                end
            end
            OP_MFR: begin
                if (busy) begin
                    emit_action(K_REFUSED, '0);
                end else begin
                    emit_action(K_SEND, OPC_MFR);
                    for (int i = 0; i < 4; i++) begin
                        emit_action(K_SEND, DUMMY);
                    end
                    emit_action(K_RELEASE, '0);
                end
            end
            default: begin
                emit_action(K_REFUSED, '0);
            end
        endcase
        if (step_actions.size() > 0) begin
            r = step_actions.pop_back();
            r.last = 1'b1;
            step_actions.push_back(r);
        end
        foreach (step_actions[i]) begin
            actions_due.push_back(step_actions[i]);
        end
    endtask

    task automatic add_request(input logic [2:0] op, input logic [ADDR_W-1:0] a,
                               input logic [LEN_W-1:0] n, input logic [BYTE_W-1:0] d);
        t_request rq;
        rq.op   = op;
        rq.addr = a;
        rq.len  = n;
        rq.data = d;
        pending_requests.push_back(rq);
    endtask

    // an item that the current transfer state refuses or ignores
    task automatic add_noise(input t_mode ctx);
        logic [2:0]       op;
        logic [LEN_W-1:0] n;
        op = 3'($urandom_range(0, 7));
        n  = rand_len();
        case (ctx)
            MODE_WRITE: begin
                while (op == OP_DATA) op = 3'($urandom_range(0, 7));
            end
            MODE_READ: begin
                while (op == OP_SLOT) op = 3'($urandom_range(0, 7));
            end
            default: begin
                while (op == OP_ERASE || op == OP_JEDEC || op == OP_MFR) begin
                    op = 3'($urandom_range(0, 7));
                end
                if (op == OP_WRITE_REQ || op == OP_READ_REQ) n = '0;
            end
        endcase
        add_request(op, rand_addr(), n, rand_byte());
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                sent_request = pending_requests.pop_front();
                predict_link_actions(sent_request);
            end
            if (pending_requests.size() > 0 && !take_gap()) begin
                push        <= 1'b1;
                i_op        <= pending_requests[0].op;
                i_address   <= pending_requests[0].addr;
                i_length    <= pending_requests[0].len;
                i_data_byte <= pending_requests[0].data;
            end else begin
                push <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (actions_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected action kind %0d value %h last %0d",
                                              o_kind, o_value, o_last));
                end else begin
                    due_action = actions_due.pop_front();
                    if (o_kind !== due_action.kind) begin
                        report_mismatch($sformatf("kind %0d, expected %0d",
                                                  o_kind, due_action.kind));
                    end
                    if (o_value !== due_action.value) begin
                        report_mismatch($sformatf("value %h, expected %h",
                                                  o_value, due_action.value));
                    end
                    if (o_last !== due_action.last) begin
                        report_mismatch($sformatf("last %0d, expected %0d",
                                                  o_last, due_action.last));
                    end
                end
                action_count++;
            end
            pop <= !take_gap();
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [ADDR_W-1:0] a;
        logic [LEN_W-1:0]  n;
        int                random_from;
        int                pick;

        add_request(OP_JEDEC, '0, '0, '0);
        add_request(OP_MFR, '1, '1, '1);
        add_request(OP_ERASE, '0, rand_len(), rand_byte());
        add_request(OP_ERASE, '1, rand_len(), rand_byte());
        add_request(OP_WRITE_REQ, rand_addr(), '0, rand_byte());
        add_request(OP_READ_REQ, rand_addr(), '0, rand_byte());
        add_request(OP_DATA, rand_addr(), rand_len(), 8'h5A);
        add_request(OP_SLOT, rand_addr(), rand_len(), rand_byte());
        add_request(OP_UNKNOWN, rand_addr(), rand_len(), rand_byte());
        add_request(OP_WRITE_REQ, 24'hFFFFFE, 25'd3, rand_byte());
        add_request(OP_READ_REQ, rand_addr(), 25'd1, rand_byte());
        add_request(OP_SLOT, rand_addr(), rand_len(), rand_byte());
        add_request(OP_DATA, rand_addr(), rand_len(), 8'h00);
        add_request(OP_DATA, rand_addr(), rand_len(), 8'hFF);
        add_request(OP_DATA, rand_addr(), rand_len(), 8'hA5);
        add_request(OP_READ_REQ, 24'hFFFFFF, 25'd2, rand_byte());
        add_request(OP_DATA, rand_addr(), rand_len(), rand_byte());
        add_request(OP_SLOT, rand_addr(), rand_len(), rand_byte());
        add_request(OP_SLOT, rand_addr(), rand_len(), rand_byte());

        // one write spanning a full page frame
        random_from = pending_requests.size();
        a = rand_addr();
        a[7:0] = 8'hFE;
        add_request(OP_WRITE_REQ, a, 25'd260, rand_byte());
        for (int i = 0; i < 260; i++) begin
            add_request(OP_DATA, rand_addr(), rand_len(), rand_byte());
        end

        while (pending_requests.size() - random_from < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                a = rand_addr();
                if ($urandom_range(0, 1) == 1) a[7:0] = 8'hFF - 8'($urandom_range(0, 15));
                n = (pick < 6) ? 25'($urandom_range(13, 40)) : 25'($urandom_range(1, 12));
                add_request(OP_WRITE_REQ, a, n, rand_byte());
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(0, 9) == 0) add_noise(MODE_WRITE);
                    add_request(OP_DATA, rand_addr(), rand_len(), rand_byte());
                end
            end else if (pick < 60) begin
                n = 25'($urandom_range(1, 8));
                add_request(OP_READ_REQ, rand_addr(), n, rand_byte());
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(0, 9) == 0) add_noise(MODE_READ);
                    add_request(OP_SLOT, rand_addr(), rand_len(), rand_byte());
                end
            end else if (pick < 84) begin
                add_request((pick < 68) ? OP_ERASE : (pick < 76) ? OP_JEDEC : OP_MFR,
                            rand_addr(), rand_len(), rand_byte());
            end else begin
                add_noise(MODE_IDLE);
            end
        end

        // full 25-bit length: the transfer never completes, so it closes the run
        add_request(OP_WRITE_REQ, 24'hFFFFFE, '1, rand_byte());
        add_request(OP_DATA, rand_addr(), rand_len(), 8'h00);
        add_request(OP_DATA, rand_addr(), rand_len(), 8'hFF);
        add_request(OP_DATA, rand_addr(), rand_len(), 8'h5A);
        add_request(OP_MFR, rand_addr(), rand_len(), rand_byte());
        add_request(OP_SLOT, rand_addr(), rand_len(), rand_byte());
        add_request(OP_DATA, rand_addr(), rand_len(), 8'hC3);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() > 0 || actions_due.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
